>>> sv/scg_pkg.sv
package scg_pkg;

    // request type codes
    localparam logic [3:0] REQ_UNIT_READY    = 4'd0;
    localparam logic [3:0] REQ_CAPACITY      = 4'd1;
    localparam logic [3:0] REQ_WRITABLE      = 4'd2;
    localparam logic [3:0] REQ_START_STOP    = 4'd3;
    localparam logic [3:0] REQ_PREVENT_ALLOW = 4'd4;
    localparam logic [3:0] REQ_READ          = 4'd5;
    localparam logic [3:0] REQ_WRITE         = 4'd6;
    localparam logic [3:0] REQ_OTHER         = 4'd7;
    localparam logic [3:0] REQ_INQUIRY       = 4'd8;
    localparam logic [3:0] REQ_SET_MEDIA     = 4'd9;
    localparam logic [3:0] REQ_DISCONNECT    = 4'd10;
    localparam logic [3:0] REQ_RESET_SESSION = 4'd11;

    // configuration register indexes
    localparam logic [1:0] CFG_OWNER        = 2'd0;
    localparam logic [1:0] CFG_MEDIA_BLOCKS = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BYTES  = 2'd2;

    // sense keys
    localparam logic [3:0] KEY_NOT_READY     = 4'h2;
    localparam logic [3:0] KEY_MEDIUM_ERROR  = 4'h3;
    localparam logic [3:0] KEY_ILLEGAL_REQ   = 4'h5;

    // additional sense codes and qualifiers
    localparam logic [7:0] ASC_BAD_LUN       = 8'h25;
    localparam logic [7:0] ASC_NO_MEDIUM     = 8'h3a;
    localparam logic [7:0] ASC_BAD_CDB_FIELD = 8'h24;
    localparam logic [7:0] ASC_LBA_RANGE     = 8'h21;
    localparam logic [7:0] ASC_READ_ERROR    = 8'h11;
    localparam logic [7:0] ASC_WRITE_ERROR   = 8'h0c;
    localparam logic [7:0] ASCQ_NONE         = 8'h00;
    localparam logic [7:0] ASCQ_WRITE_ERROR  = 8'h02;
    localparam logic [7:0] ASC_BAD_OPCODE    = 8'h20;

    // disconnect actions
    localparam logic [1:0] DISC_NONE        = 2'd0;
    localparam logic [1:0] DISC_SAFE_RETURN = 2'd1;
    localparam logic [1:0] DISC_NOTIFY      = 2'd2;

    localparam logic [12:0] CAP_BLOCK_BYTES   = 13'd512;
    localparam logic [12:0] BLOCK_BYTES_RESET = 13'd512;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [7:0]  lun;
        logic [31:0] lba;
        logic [31:0] byte_offset;
        logic [31:0] transfer_bytes;
        logic        buffer_valid;
        logic [3:0]  pwr_cond;
        logic        start_bit;
        logic        loej;
        logic        storage_ok;
        logic        media_value;
    } scg_req_t;

    typedef struct packed {
        logic        ok;
        logic        sense_set;
        logic [3:0]  sense_key;
        logic [7:0]  sense_asc;
        logic [7:0]  sense_ascq;
        logic [31:0] reported_blocks;
        logic [12:0] reported_block_bytes;
        logic [12:0] byte_count;
        logic [1:0]  disconnect_action;
        logic        media_ready;
        logic        eject_flag;
    } scg_rsp_t;

endpackage

>>> sv/scsi_command_gate.sv
// Mass-storage command gate.
// Input channel (s_*): one SCSI-level request or firmware event per request,
// accepted when s_valid and s_ready are both high.
// Result channel (m_*): exactly one result per request, in order, held
// stable while m_valid is high and m_ready is low.
// Configuration channel (cfg_*): register index and data, always ready; the
// user must have it written only while no request is in flight; unenforced.
// A request passes through two registers: the input register, then the
// result register. Throughput: one request per cycle unless the result
// stalls; the media flags live in one register pair that is updated as a
// request moves from the input register to the result register, so each
// request sees the flags its predecessor left.
// Stall: a stalled result holds; the input register still takes a request
// while the result waits, and s_ready drops only when both are full.
// Reset (aresetn low, synchronous): both channels empty, the medium-present
// and host-eject flags cleared, owner 0, media_blocks 0, block_bytes 512.
module scsi_command_gate (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    // requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_req_type,
    input  logic [7:0]  s_lun,
    input  logic [31:0] s_lba,
    input  logic [31:0] s_byte_offset,
    input  logic [31:0] s_transfer_bytes,
    input  logic        s_buffer_valid,
    input  logic [3:0]  s_pwr_cond,
    input  logic        s_start_bit,
    input  logic        s_loej,
    input  logic        s_storage_ok,
    input  logic        s_media_value,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic        m_sense_set,
    output logic [3:0]  m_sense_key,
    output logic [7:0]  m_sense_asc,
    output logic [7:0]  m_sense_ascq,
    output logic [31:0] m_reported_blocks,
    output logic [12:0] m_reported_block_bytes,
    output logic [12:0] m_byte_count,
    output logic [1:0]  m_disconnect_action,
    output logic        m_media_ready,
    output logic        m_eject_flag
);
    import scg_pkg::*;

    logic        owner_reg;
    logic [31:0] media_blocks_reg;
    logic [12:0] block_bytes_reg;
    logic        present_reg, present_next;
    logic        ejected_reg, ejected_next;

    logic        in_valid_reg;
    scg_req_t    in_reg;
    logic        out_valid_reg;
    scg_rsp_t    out_reg, out_next;

    logic        advance;
    logic        lun_ok;
    logic        ready_now;
    logic        xfer_bad;

    // handshake
    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_reg        <= 1'b0;
            media_blocks_reg <= '0;
            block_bytes_reg  <= BLOCK_BYTES_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_OWNER:        owner_reg        <= cfg_data[0];
                CFG_MEDIA_BLOCKS: media_blocks_reg <= cfg_data;
                CFG_BLOCK_BYTES:  block_bytes_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.req_type        <= s_req_type;
            in_reg.lun             <= s_lun;
            in_reg.lba             <= s_lba;
            in_reg.byte_offset     <= s_byte_offset;
            in_reg.transfer_bytes  <= s_transfer_bytes;
            in_reg.buffer_valid    <= s_buffer_valid;
            in_reg.pwr_cond        <= s_pwr_cond;
            in_reg.start_bit       <= s_start_bit;
            in_reg.loej            <= s_loej;
            in_reg.storage_ok      <= s_storage_ok;
            in_reg.media_value     <= s_media_value;
        end
    end

    // common checks
    assign lun_ok    = (in_reg.lun == 8'd0);
    assign ready_now = present_reg && owner_reg;
    assign xfer_bad  = !in_reg.buffer_valid
                    || (in_reg.lba >= media_blocks_reg)
                    || (in_reg.byte_offset != 32'd0)
                    || (in_reg.transfer_bytes != {19'd0, block_bytes_reg});

    // request decode, sense and flag update
    always_comb begin
        out_next     = '0;
        present_next = present_reg;
        ejected_next = ejected_reg;
        case (in_reg.req_type)
            REQ_UNIT_READY, REQ_WRITABLE, REQ_PREVENT_ALLOW: begin
                if (!lun_ok) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_BAD_LUN;
                end else if (ready_now) begin
                    out_next.ok = 1'b1;
                end else begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_NOT_READY;
                    out_next.sense_asc = ASC_NO_MEDIUM;
                end
            end
            REQ_CAPACITY: begin
                out_next.reported_block_bytes = CAP_BLOCK_BYTES;
                if (lun_ok && ready_now) begin
                    out_next.reported_blocks = media_blocks_reg;
                end
                if (lun_ok && ready_now && media_blocks_reg != 32'd0) begin
                    out_next.ok = 1'b1;
                end else if (!lun_ok) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_BAD_LUN;
                end else begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_NOT_READY;
                    out_next.sense_asc = ASC_NO_MEDIUM;
                end
            end
            REQ_START_STOP: begin
                if (!lun_ok) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_BAD_LUN;
                end else if (in_reg.pwr_cond != 4'd0) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_BAD_CDB_FIELD;
                end else if (in_reg.loej && !in_reg.start_bit) begin
                    // host eject
                    ejected_next = 1'b1;
                    present_next = 1'b0;
                    out_next.ok  = 1'b1;
                end else if (in_reg.start_bit) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_NOT_READY;
                    out_next.sense_asc = ASC_NO_MEDIUM;
                end else begin
                    out_next.ok = 1'b1;
                end
            end
            REQ_READ, REQ_WRITE: begin
                if (!lun_ok) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_BAD_LUN;
                end else if (!ready_now) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_NOT_READY;
                    out_next.sense_asc = ASC_NO_MEDIUM;
                end else if (xfer_bad) begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_LBA_RANGE;
                end else if (in_reg.storage_ok) begin
                    out_next.ok         = 1'b1;
                    out_next.byte_count = in_reg.transfer_bytes[12:0];
                end else begin
                    // storage failure drops the medium
                    present_next       = 1'b0;
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_MEDIUM_ERROR;
                    if (in_reg.req_type == REQ_READ) begin
                        out_next.sense_asc  = ASC_READ_ERROR;
                        out_next.sense_ascq = ASCQ_NONE;
                    end else begin
                        out_next.sense_asc  = ASC_WRITE_ERROR;
                        out_next.sense_ascq = ASCQ_WRITE_ERROR;
                    end
                end
            end
            REQ_OTHER: begin
                out_next.sense_set = 1'b1;
                out_next.sense_key = KEY_ILLEGAL_REQ;
                out_next.sense_asc = lun_ok ? ASC_BAD_OPCODE : ASC_BAD_LUN;
            end
            REQ_INQUIRY: begin
                if (lun_ok) begin
                    out_next.ok = 1'b1;
                end else begin
                    out_next.sense_set = 1'b1;
                    out_next.sense_key = KEY_ILLEGAL_REQ;
                    out_next.sense_asc = ASC_BAD_LUN;
                end
            end
            REQ_SET_MEDIA: begin
                if (!(in_reg.media_value
                      && (!owner_reg || media_blocks_reg == 32'd0))) begin
                    present_next = in_reg.media_value;
                    if (in_reg.media_value) begin
                        ejected_next = 1'b0;
                    end
                    out_next.ok = 1'b1;
                end
            end
            REQ_DISCONNECT: begin
                present_next = 1'b0;
                out_next.disconnect_action = ejected_reg ? DISC_SAFE_RETURN : DISC_NOTIFY;
                out_next.ok = 1'b1;
            end
            REQ_RESET_SESSION: begin
                ejected_next = 1'b0;
                out_next.ok  = 1'b1;
            end
            default: ;
        endcase
        out_next.media_ready = present_next && owner_reg;
        out_next.eject_flag  = ejected_next;
    end

    // media flags and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg   <= 1'b0;
            ejected_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                present_reg <= present_next;
                ejected_reg <= ejected_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_ok                   = out_reg.ok;
    assign m_sense_set            = out_reg.sense_set;
    assign m_sense_key            = out_reg.sense_key;
    assign m_sense_asc            = out_reg.sense_asc;
    assign m_sense_ascq           = out_reg.sense_ascq;
    assign m_reported_blocks      = out_reg.reported_blocks;
    assign m_reported_block_bytes = out_reg.reported_block_bytes;
    assign m_byte_count           = out_reg.byte_count;
    assign m_disconnect_action    = out_reg.disconnect_action;
    assign m_media_ready          = out_reg.media_ready;
    assign m_eject_flag           = out_reg.eject_flag;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    import scg_pkg::*;

    // codes the package does not name
    localparam logic [3:0] REQ_UNUSED = 4'd15;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [3:0] KEY_NONE   = 4'h0;
    localparam logic [7:0] ASC_NONE   = 8'h00;

    // sense triples as {written, key, asc, ascq}
    localparam logic [20:0] SN_NONE       = {1'b0, KEY_NONE, ASC_NONE, ASCQ_NONE};
    localparam logic [20:0] SN_BAD_LUN    = {1'b1, KEY_ILLEGAL_REQ, ASC_BAD_LUN, ASCQ_NONE};
    localparam logic [20:0] SN_NO_MEDIUM  = {1'b1, KEY_NOT_READY, ASC_NO_MEDIUM, ASCQ_NONE};
    localparam logic [20:0] SN_BAD_FIELD  = {1'b1, KEY_ILLEGAL_REQ, ASC_BAD_CDB_FIELD, ASCQ_NONE};
    localparam logic [20:0] SN_BAD_XFER   = {1'b1, KEY_ILLEGAL_REQ, ASC_LBA_RANGE, ASCQ_NONE};
    localparam logic [20:0] SN_READ_ERR   = {1'b1, KEY_MEDIUM_ERROR, ASC_READ_ERROR, ASCQ_NONE};
    localparam logic [20:0] SN_WRITE_ERR  =
        {1'b1, KEY_MEDIUM_ERROR, ASC_WRITE_ERROR, ASCQ_WRITE_ERROR};
    localparam logic [20:0] SN_BAD_OPCODE = {1'b1, KEY_ILLEGAL_REQ, ASC_BAD_OPCODE, ASCQ_NONE};

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;

    typedef struct {
        scg_req_t req;
        bit       typed;
        scg_rsp_t want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn           = 1'b0;
    logic        cfg_valid         = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr          = '0;
    logic [31:0] cfg_data          = '0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic [3:0]  s_req_type        = '0;
    logic [7:0]  s_lun             = '0;
    logic [31:0] s_lba             = '0;
    logic [31:0] s_byte_offset     = '0;
    logic [31:0] s_transfer_bytes  = '0;
    logic        s_buffer_valid    = 1'b0;
    logic [3:0]  s_pwr_cond        = '0;
    logic        s_start_bit       = 1'b0;
    logic        s_loej            = 1'b0;
    logic        s_storage_ok      = 1'b0;
    logic        s_media_value     = 1'b0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic        m_ok;
    logic        m_sense_set;
    logic [3:0]  m_sense_key;
    logic [7:0]  m_sense_asc;
    logic [7:0]  m_sense_ascq;
    logic [31:0] m_reported_blocks;
    logic [12:0] m_reported_block_bytes;
    logic [12:0] m_byte_count;
    logic [1:0]  m_disconnect_action;
    logic        m_media_ready;
    logic        m_eject_flag;

    // mirror of the gate's registers and flags
    logic        owner_usb  = 1'b0;
    logic [31:0] blocks_cfg = '0;
    logic [12:0] bytes_cfg  = BLOCK_BYTES_RESET;
    logic        present    = 1'b0;
    logic        ejected    = 1'b0;

    scg_rsp_t due_answers[$];
    dir_row_t dir_rows[$];
    int       bad_results  = 0;
    int       results_seen = 0;
    bit       src_calm     = 1'b0;
    bit       snk_calm     = 1'b0;

    scsi_command_gate dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // answer for one request, advancing the mirrored flags
    function automatic scg_rsp_t gate_answer(scg_req_t q);
        scg_rsp_t    a;
        logic [20:0] sense;
        logic        lun_ok;
        logic        ready_now;
        logic        xfer_bad;
        a = '0;
        sense = SN_NONE;
        lun_ok = (q.lun == 8'd0);
        ready_now = present && owner_usb;
        xfer_bad = !q.buffer_valid || q.lba >= blocks_cfg || q.byte_offset != 32'd0
                   || q.transfer_bytes != {19'd0, bytes_cfg};
        case (q.req_type)
            REQ_UNIT_READY, REQ_WRITABLE, REQ_PREVENT_ALLOW: begin
                if (!lun_ok) sense = SN_BAD_LUN;
                else if (!ready_now) sense = SN_NO_MEDIUM;
                else a.ok = 1'b1;
            end
            REQ_CAPACITY: begin
                a.reported_blocks = (lun_ok && ready_now) ? blocks_cfg : 32'd0;
                a.reported_block_bytes = CAP_BLOCK_BYTES;
                a.ok = (a.reported_blocks != 32'd0);
                if (!a.ok) sense = lun_ok ? SN_NO_MEDIUM : SN_BAD_LUN;
            end
            REQ_START_STOP: begin
                if (!lun_ok) sense = SN_BAD_LUN;
                else if (q.pwr_cond != 4'd0) sense = SN_BAD_FIELD;
                else if (q.loej && !q.start_bit) begin
                    ejected = 1'b1;
                    present = 1'b0;
                    a.ok = 1'b1;
                end else if (q.start_bit) sense = SN_NO_MEDIUM;
                else a.ok = 1'b1;
            end
            REQ_READ, REQ_WRITE: begin
                if (!lun_ok) sense = SN_BAD_LUN;
                else if (!ready_now) sense = SN_NO_MEDIUM;
                else if (xfer_bad) sense = SN_BAD_XFER;
                else if (q.storage_ok) begin
                    a.ok = 1'b1;
                    a.byte_count = q.transfer_bytes[12:0];
                end else begin
                    present = 1'b0;
                    sense = (q.req_type == REQ_READ) ? SN_READ_ERR : SN_WRITE_ERR;
                end
            end
            REQ_OTHER: sense = lun_ok ? SN_BAD_OPCODE : SN_BAD_LUN;
            REQ_INQUIRY: begin
                if (lun_ok) a.ok = 1'b1;
                else sense = SN_BAD_LUN;
            end
            REQ_SET_MEDIA: begin
                // presence is refused without a host owner and a nonzero size
                if (!(q.media_value && (!owner_usb || blocks_cfg == 32'd0))) begin
                    present = q.media_value;
                    if (q.media_value) ejected = 1'b0;
                    a.ok = 1'b1;
                end
            end
            REQ_DISCONNECT: begin
                present = 1'b0;
                a.disconnect_action = ejected ? DISC_SAFE_RETURN : DISC_NOTIFY;
                a.ok = 1'b1;
            end
            REQ_RESET_SESSION: begin
                ejected = 1'b0;
                a.ok = 1'b1;
            end
            default: ;
        endcase
        {a.sense_set, a.sense_key, a.sense_asc, a.sense_ascq} = sense;
        a.media_ready = present && owner_usb;
        a.eject_flag = ejected;
        return a;
    endfunction

    function automatic scg_rsp_t mk_rsp(logic ok, logic [20:0] sense, logic [31:0] blocks,
                                        logic [12:0] rbytes, logic [12:0] count,
                                        logic [1:0] action, logic ready, logic ej);
        scg_rsp_t a;
        a = '0;
        a.ok = ok;
        {a.sense_set, a.sense_key, a.sense_asc, a.sense_ascq} = sense;
        a.reported_blocks = blocks;
        a.reported_block_bytes = rbytes;
        a.byte_count = count;
        a.disconnect_action = action;
        a.media_ready = ready;
        a.eject_flag = ej;
        return a;
    endfunction

    // well-formed request for the directed setup (4096 byte blocks)
    function automatic scg_req_t plain(logic [3:0] kind);
        scg_req_t q;
        q = '0;
        q.req_type = kind;
        q.transfer_bytes = 32'd4096;
        q.buffer_valid = 1'b1;
        q.storage_ok = 1'b1;
        q.media_value = 1'b1;
        return q;
    endfunction

    // random request, mostly well formed for the current setup
    function automatic scg_req_t rand_req();
        scg_req_t    q;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) q.req_type = REQ_READ;
        else if (pick < 44) q.req_type = REQ_WRITE;
        else if (pick < 54) q.req_type = REQ_SET_MEDIA;
        else if (pick < 62) q.req_type = REQ_START_STOP;
        else if (pick < 66) q.req_type = REQ_UNIT_READY;
        else if (pick < 69) q.req_type = REQ_CAPACITY;
        else if (pick < 72) q.req_type = REQ_WRITABLE;
        else if (pick < 75) q.req_type = REQ_PREVENT_ALLOW;
        else if (pick < 78) q.req_type = REQ_OTHER;
        else if (pick < 81) q.req_type = REQ_INQUIRY;
        else if (pick < 85) q.req_type = REQ_DISCONNECT;
        else if (pick < 88) q.req_type = REQ_RESET_SESSION;
        else q.req_type = 4'($urandom_range(0, 15));
        q.lun = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        pick = $urandom_range(0, 9);
        if (blocks_cfg != 32'd0 && pick < 7) q.lba = $urandom_range(0, blocks_cfg - 32'd1);
        else if (pick == 7) q.lba = blocks_cfg;
        else if (pick == 8) q.lba = 32'hFFFF_FFFF;
        else q.lba = $urandom;
        q.byte_offset = ($urandom_range(0, 9) < 8) ? 32'd0 : $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 8) q.transfer_bytes = {19'd0, bytes_cfg};
        else if (pick == 8) q.transfer_bytes = $urandom;
        else if ($urandom_range(0, 1) == 0) q.transfer_bytes = {19'd0, bytes_cfg} + 32'd1;
        else q.transfer_bytes = {19'd0, bytes_cfg} - 32'd1;
        q.buffer_valid = ($urandom_range(0, 15) != 0);
        q.pwr_cond = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
        q.start_bit = 1'($urandom_range(0, 1));
        q.loej = 1'($urandom_range(0, 1));
        q.storage_ok = ($urandom_range(0, 11) != 0);
        q.media_value = ($urandom_range(0, 3) != 0);
        return q;
    endfunction

    // wait draw with runs of back-to-back traffic
    function automatic int unsigned pick_wait(inout bit calm);
        if ($urandom_range(0, 29) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic add_row(scg_req_t q, bit typed, scg_rsp_t want);
        dir_row_t r;
        r.req = q;
        r.typed = typed;
        r.want = want;
        dir_rows.push_back(r);
    endtask

    // present one request and log its answer once accepted
    task automatic send(scg_req_t q, bit typed, scg_rsp_t want);
        scg_rsp_t model;
        s_valid <= 1'b1;
        {s_req_type, s_lun, s_lba, s_byte_offset, s_transfer_bytes, s_buffer_valid,
         s_pwr_cond, s_start_bit, s_loej, s_storage_ok, s_media_value} <= q;
        do @(posedge aclk); while (!s_ready);
        model = gate_answer(q);
        due_answers.push_back(typed ? want : model);
    endtask

    task automatic pause_src();
        int unsigned n;
        n = pick_wait(src_calm);
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // hold off until every answer is back
    task automatic go_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_answers.size() != 0);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_OWNER:        owner_usb = val[0];
            CFG_MEDIA_BLOCKS: blocks_cfg = val;
            CFG_BLOCK_BYTES:  bytes_cfg = val[12:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(logic owner, logic [31:0] blocks, logic [12:0] bytes);
        cfg_write(CFG_OWNER, {31'd0, owner});
        cfg_write(CFG_MEDIA_BLOCKS, blocks);
        if ($urandom_range(0, 3) == 0) cfg_write(CFG_UNUSED, $urandom);
        cfg_write(CFG_BLOCK_BYTES, {19'd0, bytes});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_rows(int first, int last);
        for (int i = first; i <= last; i++) begin
            send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            if (i != last) pause_src();
        end
        go_idle();
    endtask

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            bad_results++;
            if (bad_results <= 10)
                $display("result %0d: %s expected %0h got %0h", results_seen, fname, want, got);
        end
    endtask

    // result side: random stalls, compare against the oldest answer
    initial begin : result_sink
        int unsigned n;
        scg_rsp_t    got;
        scg_rsp_t    want;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            n = pick_wait(snk_calm);
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = {m_ok, m_sense_set, m_sense_key, m_sense_asc, m_sense_ascq,
                   m_reported_blocks, m_reported_block_bytes, m_byte_count,
                   m_disconnect_action, m_media_ready, m_eject_flag};
            if (due_answers.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d arrived with no request pending", results_seen);
            end else begin
                want = due_answers.pop_front();
                check_field("ok", 32'(want.ok), 32'(got.ok));
                check_field("sense_set", 32'(want.sense_set), 32'(got.sense_set));
                check_field("sense_key", 32'(want.sense_key), 32'(got.sense_key));
                check_field("sense_asc", 32'(want.sense_asc), 32'(got.sense_asc));
                check_field("sense_ascq", 32'(want.sense_ascq), 32'(got.sense_ascq));
                check_field("reported_blocks", want.reported_blocks, got.reported_blocks);
                check_field("reported_block_bytes", 32'(want.reported_block_bytes),
                            32'(got.reported_block_bytes));
                check_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
                check_field("disconnect_action", 32'(want.disconnect_action),
                            32'(got.disconnect_action));
                check_field("media_ready", 32'(want.media_ready), 32'(got.media_ready));
                check_field("eject_flag", 32'(want.eject_flag), 32'(got.eject_flag));
            end
            results_seen++;
        end
    end

    // stimulus
    initial begin : stimulus
        scg_req_t    q;
        int          split;
        logic        owner;
        logic [31:0] blocks;
        logic [12:0] bytes;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setup: no owner, no blocks
        q = plain(REQ_UNIT_READY);
        add_row(q, 1'b1, mk_rsp(0, SN_NO_MEDIUM, 0, 0, 0, DISC_NONE, 0, 0));
        q = plain(REQ_CAPACITY); q.lun = 8'hFF;
        add_row(q, 1'b1, mk_rsp(0, SN_BAD_LUN, 0, CAP_BLOCK_BYTES, 0, DISC_NONE, 0, 0));
        q = plain(REQ_SET_MEDIA);
        add_row(q, 1'b1, mk_rsp(0, SN_NONE, 0, 0, 0, DISC_NONE, 0, 0));
        q = '1; q.req_type = REQ_UNUSED;
        add_row(q, 1'b1, mk_rsp(0, SN_NONE, 0, 0, 0, DISC_NONE, 0, 0));
        q = plain(REQ_SET_MEDIA); q.media_value = 1'b0;
        add_row(q, 1'b1, mk_rsp(1, SN_NONE, 0, 0, 0, DISC_NONE, 0, 0));
        q = plain(REQ_DISCONNECT);
        add_row(q, 1'b1, mk_rsp(1, SN_NONE, 0, 0, 0, DISC_NOTIFY, 0, 0));
        split = dir_rows.size();

        // host owner, largest medium, 4096-byte blocks
        q = plain(REQ_SET_MEDIA);
        add_row(q, 1'b1, mk_rsp(1, SN_NONE, 0, 0, 0, DISC_NONE, 1, 0));
        q = plain(REQ_CAPACITY);
        add_row(q, 1'b1, mk_rsp(1, SN_NONE, 32'hFFFF_FFFF, CAP_BLOCK_BYTES, 0, DISC_NONE,
                                1, 0));
        q = plain(REQ_READ); q.lba = 32'hFFFF_FFFE;
        add_row(q, 1'b1, mk_rsp(1, SN_NONE, 0, 0, 13'd4096, DISC_NONE, 1, 0));
        q = plain(REQ_READ); q.lba = 32'hFFFF_FFFF;
        add_row(q, 1'b1, mk_rsp(0, SN_BAD_XFER, 0, 0, 0, DISC_NONE, 1, 0));
        q = plain(REQ_WRITE); q.byte_offset = 32'hFFFF_FFFF;
        add_row(q, 1'b0, '0);
        q = plain(REQ_READ); q.buffer_valid = 1'b0;
        add_row(q, 1'b0, '0);
        q = plain(REQ_READ); q.lun = 8'd1;
        add_row(q, 1'b1, mk_rsp(0, SN_BAD_LUN, 0, 0, 0, DISC_NONE, 1, 0));
        q = plain(REQ_WRITE); q.storage_ok = 1'b0;
        add_row(q, 1'b1, mk_rsp(0, SN_WRITE_ERR, 0, 0, 0, DISC_NONE, 0, 0));
        add_row(plain(REQ_SET_MEDIA), 1'b0, '0);
        q = plain(REQ_READ); q.storage_ok = 1'b0;
        add_row(q, 1'b1, mk_rsp(0, SN_READ_ERR, 0, 0, 0, DISC_NONE, 0, 0));
        add_row(plain(REQ_SET_MEDIA), 1'b0, '0);
        q = plain(REQ_START_STOP); q.pwr_cond = 4'hF;
        add_row(q, 1'b1, mk_rsp(0, SN_BAD_FIELD, 0, 0, 0, DISC_NONE, 1, 0));
        q = plain(REQ_START_STOP); q.start_bit = 1'b1;
        add_row(q, 1'b0, '0);
        add_row(plain(REQ_START_STOP), 1'b0, '0);
        q = plain(REQ_START_STOP); q.loej = 1'b1;
        add_row(q, 1'b1, mk_rsp(1, SN_NONE, 0, 0, 0, DISC_NONE, 0, 1));
        add_row(plain(REQ_DISCONNECT), 1'b1,
                mk_rsp(1, SN_NONE, 0, 0, 0, DISC_SAFE_RETURN, 0, 1));
        add_row(plain(REQ_RESET_SESSION), 1'b0, '0);
        add_row(plain(REQ_OTHER), 1'b1, mk_rsp(0, SN_BAD_OPCODE, 0, 0, 0, DISC_NONE, 0, 0));
        q = plain(REQ_INQUIRY); q.lun = 8'h80;
        add_row(q, 1'b0, '0);
        add_row(plain(REQ_WRITABLE), 1'b0, '0);
        add_row(plain(REQ_PREVENT_ALLOW), 1'b0, '0);

        run_rows(0, split - 1);
        cfg_write(CFG_OWNER, 32'd1);
        cfg_write(CFG_MEDIA_BLOCKS, 32'hFFFF_FFFF);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_write(CFG_BLOCK_BYTES, 32'd4096);
        cfg_valid <= 1'b0;
        run_rows(split, dir_rows.size() - 1);

        // random phases, each under its own setup
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin owner = 1'b1; blocks = 32'd1;           bytes = 13'd1;    end
                1: begin owner = 1'b0; blocks = $urandom;        bytes = 13'd4096; end
                2: begin owner = 1'b1; blocks = 32'd0;           bytes = 13'd512;  end
                3: begin owner = 1'b1; blocks = 32'hFFFF_FFFF;   bytes = 13'd4096; end
                default: begin
                    owner = ($urandom_range(0, 5) != 0);
                    blocks = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom;
                    bytes = 13'($urandom_range(1, 4096));
                end
            endcase
            apply_config(owner, blocks, bytes);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send(rand_req(), 1'b0, '0);
                if (k == PHASE_ITEMS - 1) ;
                else if ($urandom_range(0, 199) == 0) go_idle();
                else pause_src();
            end
            go_idle();
        end

        // drain, then wait for stray results
        repeat (8) @(posedge aclk);
        bad_results += due_answers.size();
        if (bad_results == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
